@@ hdl/chc_pkg.sv @@
package chc_pkg;

   localparam int CHAN_FIELD_BITS = 5;
   localparam int FREQ_FIELD_BITS = 16;

   typedef enum logic [1:0] {
      CMD_ADD   = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_START = 2'd2,
      CMD_NEXT  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      cmd_type                    command;
      logic [CHAN_FIELD_BITS-1:0] red;
      logic [CHAN_FIELD_BITS-1:0] green;
      logic [CHAN_FIELD_BITS-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [FREQ_FIELD_BITS-1:0] frequency;
      logic [CHAN_FIELD_BITS-1:0] position_red;
      logic [CHAN_FIELD_BITS-1:0] position_green;
      logic [CHAN_FIELD_BITS-1:0] position_blue;
      logic                       found;
   } rsp_type;

endpackage

@@ hdl/chc_bin_ram.sv @@
module chc_bin_ram #(
   parameter int ADDR_BITS = 15,
   parameter int DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/color_histogram_counter_unit.sv @@
// Channel  Ports                          Payload    Direction
// req      req_valid/req_stall/req_data   req_type   in
// rsp      rsp_valid/rsp_stall/rsp_data   rsp_type   out
//
// Add and query: accept and read in idle, then modify/write back and load result in lookup.
// Start and next: accept in idle, then scan the bins, one read per cycle.
// After reset the count memory is cleared, one entry per cycle, all
// 2**(3*CHANNEL_BITS) entries (32768 at default), with req_stall high.
// A finished result waits in a pending register while rsp_stall is high.
module color_histogram_counter_unit
   import chc_pkg::*;
#(
   parameter int CHANNEL_BITS = 5,
   parameter int COUNT_BITS   = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_BITS = 3 * CHANNEL_BITS;

   state_type             state_ff, state_in;
   logic [IDX_BITS-1:0]   clr_addr_ff, clr_addr_in;
   cmd_type               cmd_ff, cmd_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [IDX_BITS:0]     scan_addr_ff, scan_addr_in;
   logic [IDX_BITS-1:0]   chk_addr_ff, chk_addr_in;
   logic                  data_vld_ff, data_vld_in;
   logic [IDX_BITS-1:0]   iter_pos_ff, iter_pos_in;
   logic                  iter_vld_ff, iter_vld_in;
   rsp_type               pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [COUNT_BITS-1:0] rd_data;

   logic [IDX_BITS-1:0]   req_idx;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic                  scan_hit;
   logic                  rsp_free;
   logic                  done;
   rsp_type               res;

   chc_bin_ram #(
      .ADDR_BITS (IDX_BITS),
      .DATA_BITS (COUNT_BITS)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_idx = {CHANNEL_BITS'(req_data.red), CHANNEL_BITS'(req_data.green),
                     CHANNEL_BITS'(req_data.blue)};
   assign cnt_inc  = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);
   assign scan_hit = data_vld_ff && (rd_data != '0);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // add writes back at the end of lookup; the next read is issued in idle, after
   // the write has landed, so no forwarding path is needed
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      scan_addr_in = scan_addr_ff;
      chk_addr_in  = chk_addr_ff;
      data_vld_in  = 1'b0;
      iter_pos_in  = iter_pos_ff;
      iter_vld_in  = iter_vld_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = '0;
      rd_addr      = req_idx;
      done         = 1'b0;
      res          = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + IDX_BITS'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in = req_data.command;
               idx_in = req_idx;
               unique case (req_data.command)
                  CMD_ADD, CMD_QUERY: begin
                     state_in = ST_LOOKUP;
                  end
                  CMD_START: begin
                     scan_addr_in = '0;
                     state_in     = ST_SCAN;
                  end
                  CMD_NEXT: begin
                     // invalid iterator: start past the end, ends with no hit
                     scan_addr_in = iter_vld_ff ?
                                    {1'b0, iter_pos_ff} + (IDX_BITS + 1)'(1) :
                                    {1'b1, {IDX_BITS{1'b0}}};
                     state_in     = ST_SCAN;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            wr_addr            = idx_ff;
            wr_data            = cnt_inc;
            res.position_red   = CHAN_FIELD_BITS'(idx_ff[IDX_BITS-1 -: CHANNEL_BITS]);
            res.position_green = CHAN_FIELD_BITS'(idx_ff[2*CHANNEL_BITS-1 -: CHANNEL_BITS]);
            res.position_blue  = CHAN_FIELD_BITS'(idx_ff[CHANNEL_BITS-1:0]);
            if (cmd_ff == CMD_ADD) begin
               wr_en         = 1'b1;
               res.frequency = FREQ_FIELD_BITS'(cnt_inc);
               res.found     = 1'b1;
            end else begin
               res.frequency = FREQ_FIELD_BITS'(rd_data);
               res.found     = (rd_data != '0);
            end
            done = 1'b1;
         end
         ST_SCAN: begin
            rd_addr = scan_addr_ff[IDX_BITS-1:0];
            priority if (scan_hit) begin
               iter_pos_in        = chk_addr_ff;
               iter_vld_in        = 1'b1;
               res.frequency      = FREQ_FIELD_BITS'(rd_data);
               res.position_red   = CHAN_FIELD_BITS'(chk_addr_ff[IDX_BITS-1 -: CHANNEL_BITS]);
               res.position_green =
                  CHAN_FIELD_BITS'(chk_addr_ff[2*CHANNEL_BITS-1 -: CHANNEL_BITS]);
               res.position_blue  = CHAN_FIELD_BITS'(chk_addr_ff[CHANNEL_BITS-1:0]);
               res.found          = 1'b1;
               done               = 1'b1;
            end else if (scan_addr_ff[IDX_BITS]) begin
               iter_vld_in = 1'b0;
               done        = 1'b1;
            end else begin
               data_vld_in  = 1'b1;
               chk_addr_in  = scan_addr_ff[IDX_BITS-1:0];
               scan_addr_in = scan_addr_ff + (IDX_BITS + 1)'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = res;
            state_in = ST_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         data_vld_ff  <= 1'b0;
         iter_pos_ff  <= '0;
         iter_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         data_vld_ff  <= data_vld_in;
         iter_pos_ff  <= iter_pos_in;
         iter_vld_ff  <= iter_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      scan_addr_ff <= scan_addr_in;
      chk_addr_ff  <= chk_addr_in;
      pend_ff      <= pend_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !rsp_valid_ff)
      else $error("result present during memory clear");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff != ST_IDLE)
      else $error("accepted beat did not start work");

   a_add_nonzero: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff == ST_LOOKUP) |-> wr_data != '0)
      else $error("add wrote a zero count");

   a_hit_sets_iter: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_hit) |=> iter_vld_ff && iter_pos_ff == $past(chk_addr_ff))
      else $error("scan hit did not update iterator");

endmodule
